### src/qts_pkg.sv
// Package of the quoted token splitter: character codes, scan modes,
// error codes, the result word type and the token limit.
// No dependencies.
`default_nettype none
package qts_pkg;

  localparam int MAX_TOKENS = 64;
  localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
  localparam int IDX_W      = 6;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TOKENS);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;

  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_QUOTED  = 3'd1,
    MODE_ESCAPE  = 3'd2,
    MODE_BARE    = 3'd3,
    MODE_DISCARD = 3'd4
  } scan_mode_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_TOO_MANY   = 2'd1,
    ERR_OPEN_QUOTE = 2'd2,
    ERR_BAD_ESCAPE = 2'd3
  } err_code_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic [IDX_W-1:0] token_index;
    logic             token_done;
    logic             line_done;
    err_code_t        error_code;
  } qts_result_t;

  typedef struct packed {
    scan_mode_t       mode;
    logic [CNT_W-1:0] count;
  } qts_status_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) || (c == CH_CR);
  endfunction

endpackage
`default_nettype wire

### src/qts_in_stage.sv
// Input register of the quoted token splitter: holds one byte word.
// Depends on qts_pkg.
`default_nettype none
module qts_in_stage import qts_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            hold_valid,
  output logic [7:0]      hold_byte,
  input  wire logic       take
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // stall only while a held word cannot move on
  assign in_stall   = valid_r && !take;
  assign valid_nxt  = in_stall ? 1'b1 : in_valid;
  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_byte;
    end
  end

endmodule
`default_nettype wire

### src/qts_scanner.sv
// Scanner of the quoted token splitter: scan mode and token count registers,
// next-state logic and the result of one byte. Depends on qts_pkg.
`default_nettype none
module qts_scanner import qts_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] c,
  output logic            res_valid,
  output qts_result_t     res,
  output qts_status_t     status
);

  scan_mode_t       mode_r, mode_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] count_inc;
  logic             sp;
  logic             esc_ok;
  logic [7:0]       esc_byte;

  assign count_inc = count_r + CNT_W'(1);
  assign sp        = is_space(c);
  assign status    = '{mode: mode_r, count: count_r};

  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = c;
    priority if (c == CH_N) esc_byte = CH_LF;
    else if (c == CH_R) esc_byte = CH_CR;
    else if (c == CH_T) esc_byte = CH_TAB;
    else if (c == CH_BSL || c == CH_QUOTE) esc_byte = c;
    else esc_ok = 1'b0;
  end

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    unique case (mode_r)
      MODE_BETWEEN: begin
        priority if (c == CH_NUL) begin
          count_nxt = '0;
        end else if (sp) begin
          mode_nxt = MODE_BETWEEN;
        end else if (count_r >= MAX_CNT) begin
          mode_nxt = MODE_DISCARD;
        end else if (c == CH_QUOTE) begin
          mode_nxt = MODE_QUOTED;
        end else begin
          mode_nxt = MODE_BARE;
        end
      end
      MODE_QUOTED: begin
        priority if (c == CH_QUOTE) begin
          mode_nxt  = MODE_BETWEEN;
          count_nxt = count_inc;
        end else if (c == CH_BSL) begin
          mode_nxt = MODE_ESCAPE;
        end else if (c == CH_NUL) begin
          mode_nxt  = MODE_BETWEEN;
          count_nxt = '0;
        end else begin
          mode_nxt = MODE_QUOTED;
        end
      end
      MODE_ESCAPE: begin
        priority if (esc_ok) begin
          mode_nxt = MODE_QUOTED;
        end else if (c == CH_NUL) begin
          mode_nxt  = MODE_BETWEEN;
          count_nxt = '0;
        end else begin
          mode_nxt = MODE_DISCARD;
        end
      end
      MODE_BARE: begin
        priority if (c == CH_QUOTE) begin
          count_nxt = count_inc;
          mode_nxt  = (count_inc >= MAX_CNT) ? MODE_DISCARD : MODE_QUOTED;
        end else if (sp) begin
          mode_nxt  = MODE_BETWEEN;
          count_nxt = count_inc;
        end else if (c == CH_NUL) begin
          mode_nxt  = MODE_BETWEEN;
          count_nxt = '0;
        end else begin
          mode_nxt = MODE_BARE;
        end
      end
      default: begin
        if (c == CH_NUL) begin
          mode_nxt  = MODE_BETWEEN;
          count_nxt = '0;
        end
      end
    endcase
  end

  // result of this byte
  always_comb begin
    res_valid       = 1'b0;
    res.out_byte    = '0;
    res.byte_valid  = 1'b0;
    res.token_index = count_r[IDX_W-1:0];
    res.token_done  = 1'b0;
    res.line_done   = 1'b0;
    res.error_code  = ERR_NONE;
    unique case (mode_r)
      MODE_BETWEEN: begin
        priority if (c == CH_NUL) begin
          res_valid     = 1'b1;
          res.line_done = 1'b1;
        end else if (sp) begin
          res_valid = 1'b0;
        end else if (count_r >= MAX_CNT) begin
          res_valid      = 1'b1;
          res.error_code = ERR_TOO_MANY;
        end else if (c == CH_QUOTE) begin
          res_valid = 1'b0;
        end else begin
          res_valid      = 1'b1;
          res.out_byte   = c;
          res.byte_valid = 1'b1;
        end
      end
      MODE_QUOTED: begin
        priority if (c == CH_QUOTE) begin
          res_valid      = 1'b1;
          res.token_done = 1'b1;
        end else if (c == CH_BSL) begin
          res_valid = 1'b0;
        end else if (c == CH_NUL) begin
          res_valid      = 1'b1;
          res.line_done  = 1'b1;
          res.error_code = ERR_OPEN_QUOTE;
        end else begin
          res_valid      = 1'b1;
          res.out_byte   = c;
          res.byte_valid = 1'b1;
        end
      end
      MODE_ESCAPE: begin
        res_valid = 1'b1;
        if (esc_ok) begin
          res.out_byte   = esc_byte;
          res.byte_valid = 1'b1;
        end else begin
          res.line_done  = (c == CH_NUL);
          res.error_code = ERR_BAD_ESCAPE;
        end
      end
      MODE_BARE: begin
        res_valid = 1'b1;
        priority if (c == CH_QUOTE) begin
          res.token_done = 1'b1;
          res.error_code = (count_inc >= MAX_CNT) ? ERR_TOO_MANY : ERR_NONE;
        end else if (sp) begin
          res.token_done = 1'b1;
        end else if (c == CH_NUL) begin
          res.token_done = 1'b1;
          res.line_done  = 1'b1;
        end else begin
          res.out_byte   = c;
          res.byte_valid = 1'b1;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_BETWEEN;
      count_r <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### src/quoted_token_splitter_unit.sv
// Top level of the quoted token splitter: input register, scanner and
// result register. Depends on qts_pkg, qts_in_stage and qts_scanner.
//
// Feed one byte word of a line per accepted cycle on in_valid/in_stall/in_byte;
// a zero byte ends the line. Space, LF, tab and CR split bare tokens; a double
// quote opens a quoted token in which backslash escapes n, r, t, backslash and
// quote are translated. Each byte gives at most one result word on
// out_valid/out_stall: a token character, a token end, a line end or an error
// code. Whitespace and an opening quote between tokens and a backslash in a quoted
// token give no word. The input register takes the byte, then the result register
// loads the scanner's word.
// Throughput: one byte per cycle while out_stall is low, as scan mode and token
// count update in the same cycle as the character compares.
// After an error, drop bytes up to and including the next zero byte.
// Reset (rst_n low, synchronous) empties both registers and returns the scanner
// to between tokens with a token count of zero.
// When the receiver stalls, hold the result word; the input register takes one
// more word, and once both are full in_stall follows out_stall in that cycle.
`default_nettype none
module quoted_token_splitter_unit import qts_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_byte,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_byte_valid,
  output logic [IDX_W-1:0]      out_token_index,
  output logic                  out_token_done,
  output logic                  out_line_done,
  output logic [1:0]            out_error_code
);

  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        out_free;
  logic        step;
  logic        res_valid;
  logic        out_load;
  qts_result_t res;
  qts_status_t status;

  logic        out_valid_r, out_valid_nxt;
  qts_result_t out_r;

  // advance when the result register is empty or is being drained
  assign out_free = !out_valid_r || !out_stall;
  assign step     = hold_valid && out_free;
  assign out_load = step && res_valid;

  qts_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .take       (out_free)
  );

  qts_scanner u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .c         (hold_byte),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  // hold the word under stall, otherwise load whatever the scanner gives
  assign out_valid_nxt = out_free ? out_load : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_r.out_byte;
  assign out_byte_valid  = out_r.byte_valid;
  assign out_token_index = out_r.token_index;
  assign out_token_done  = out_r.token_done;
  assign out_line_done   = out_r.line_done;
  assign out_error_code  = out_r.error_code;

`ifndef SYNTH
  // backpressure on the input only comes from a stalled result word
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result word");

  // the token count never passes the limit
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.count <= MAX_CNT)
    else $error("token count beyond limit");

  // a line end word leaves the scanner on a fresh line
  a_line_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res.line_done) |=>
      (status.count == '0 && status.mode == MODE_BETWEEN))
    else $error("line end did not clear scanner state");
`endif

endmodule
`default_nettype wire

### verif/tb_quoted_token_splitter_unit.sv
// Self-checking testbench for quoted_token_splitter_unit: a directed table and random lines,
// with every result word checked against a typed row or a cycle-free scanner model in this file.
// Depends on qts_pkg and the RTL of quoted_token_splitter_unit.
module tb_quoted_token_splitter_unit import qts_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Run limits: the watchdog allows many times the slowest legal run, the drain covers
  // the two-register latency with margin.
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 150;
  localparam int PHASE_BYTES  = 430;
  localparam int MAX_REPORTS  = 10;

  // Shapes of generated lines: mostly well-formed, the rest broken or pure noise.
  typedef enum int {
    LK_PLAIN, LK_NOISE, LK_OPEN, LK_BAD_ESC, LK_FULL, LK_OVER, LK_AT_LIMIT
  } line_kind_t;

  // One row of the directed table: the byte to send and, where it is obvious, the
  // word it must give. Rows without a typed word fall back on the scanner model.
  typedef struct {
    logic [7:0]  b;
    bit          typed;
    qts_result_t want;
  } dir_row_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic [7:0]       in_byte   = 8'h00;
  logic             out_stall = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             out_byte_valid;
  logic [IDX_W-1:0] out_token_index;
  logic             out_token_done;
  logic             out_line_done;
  logic [1:0]       out_error_code;

  // Side information presented alongside each byte, stable at the sampling edge.
  bit               row_typed = 1'b0;
  qts_result_t      row_want  = '0;

  // Scanner model state and the store of words still owed by the block.
  scan_mode_t       sc_mode  = MODE_BETWEEN;
  int               sc_count = 0;
  qts_result_t      want_q[$];
  int               live_bytes  = 0;
  int               fault_count = 0;
  int               cycles      = 0;

  // Idling and pressure controls shared between the stimulus and the receiver.
  int               send_pct = 0;
  int               recv_pct = 0;
  int               press_req  = 0;
  int               press_seen = 0;
  int               hold_left  = 0;

  dir_row_t         dir_tab[$];
  logic [7:0]       line_q[$];

  quoted_token_splitter_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_token_index(out_token_index),
    .out_token_done (out_token_done),
    .out_line_done  (out_line_done),
    .out_error_code (out_error_code)
  );

  // 8 ns clock, low half first.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic qts_result_t mk_word(input logic [7:0] b, input logic v,
                                          input logic [IDX_W-1:0] idx, input logic td,
                                          input logic ld, input err_code_t err);
    qts_result_t w;
    w.out_byte    = b;
    w.byte_valid  = v;
    w.token_index = idx;
    w.token_done  = td;
    w.line_done   = ld;
    w.error_code  = err;
    return w;
  endfunction

  function automatic bit is_gap(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  // Scanner model: advance the state by one byte and say whether a word results.
  // The token index wraps at 64, which only shows on a line that holds exactly 64 tokens.
  function automatic bit scan_byte(input logic [7:0] c, output qts_result_t w);
    logic [IDX_W-1:0] idx;
    logic [7:0]       t;
    idx = IDX_W'(sc_count);
    w   = '0;
    case (sc_mode)
      MODE_BETWEEN: begin
        if (c == CH_NUL) begin
          w = mk_word(8'h00, 1'b0, idx, 1'b0, 1'b1, ERR_NONE);
          sc_count = 0;
          return 1'b1;
        end
        if (is_gap(c)) return 1'b0;
        // A token would start here: refuse it once the line is full.
        if (sc_count >= MAX_TOKENS) begin
          w = mk_word(8'h00, 1'b0, idx, 1'b0, 1'b0, ERR_TOO_MANY);
          sc_mode = MODE_DISCARD;
          return 1'b1;
        end
        if (c == CH_QUOTE) begin
          sc_mode = MODE_QUOTED;
          return 1'b0;
        end
        sc_mode = MODE_BARE;
        w = mk_word(c, 1'b1, idx, 1'b0, 1'b0, ERR_NONE);
        return 1'b1;
      end
      MODE_QUOTED: begin
        if (c == CH_QUOTE) begin
          w = mk_word(8'h00, 1'b0, idx, 1'b1, 1'b0, ERR_NONE);
          sc_count++;
          sc_mode = MODE_BETWEEN;
          return 1'b1;
        end
        if (c == CH_BSL) begin
          sc_mode = MODE_ESCAPE;
          return 1'b0;
        end
        if (c == CH_NUL) begin
          w = mk_word(8'h00, 1'b0, idx, 1'b0, 1'b1, ERR_OPEN_QUOTE);
          sc_mode  = MODE_BETWEEN;
          sc_count = 0;
          return 1'b1;
        end
        w = mk_word(c, 1'b1, idx, 1'b0, 1'b0, ERR_NONE);
        return 1'b1;
      end
      MODE_ESCAPE: begin
        case (c)
          CH_N:     t = CH_LF;
          CH_R:     t = CH_CR;
          CH_T:     t = CH_TAB;
          CH_BSL:   t = CH_BSL;
          CH_QUOTE: t = CH_QUOTE;
          default: begin
            // Bad escape: a zero byte ends the line at once, anything else starts a drop.
            if (c == CH_NUL) begin
              w = mk_word(8'h00, 1'b0, idx, 1'b0, 1'b1, ERR_BAD_ESCAPE);
              sc_mode  = MODE_BETWEEN;
              sc_count = 0;
            end else begin
              w = mk_word(8'h00, 1'b0, idx, 1'b0, 1'b0, ERR_BAD_ESCAPE);
              sc_mode = MODE_DISCARD;
            end
            return 1'b1;
          end
        endcase
        sc_mode = MODE_QUOTED;
        w = mk_word(t, 1'b1, idx, 1'b0, 1'b0, ERR_NONE);
        return 1'b1;
      end
      MODE_BARE: begin
        // A quote closes the bare token and opens a quoted one, unless the line is now full.
        if (c == CH_QUOTE) begin
          sc_count++;
          if (sc_count >= MAX_TOKENS) begin
            w = mk_word(8'h00, 1'b0, idx, 1'b1, 1'b0, ERR_TOO_MANY);
            sc_mode = MODE_DISCARD;
          end else begin
            w = mk_word(8'h00, 1'b0, idx, 1'b1, 1'b0, ERR_NONE);
            sc_mode = MODE_QUOTED;
          end
          return 1'b1;
        end
        if (is_gap(c)) begin
          w = mk_word(8'h00, 1'b0, idx, 1'b1, 1'b0, ERR_NONE);
          sc_count++;
          sc_mode = MODE_BETWEEN;
          return 1'b1;
        end
        if (c == CH_NUL) begin
          w = mk_word(8'h00, 1'b0, idx, 1'b1, 1'b1, ERR_NONE);
          sc_mode  = MODE_BETWEEN;
          sc_count = 0;
          return 1'b1;
        end
        w = mk_word(c, 1'b1, idx, 1'b0, 1'b0, ERR_NONE);
        return 1'b1;
      end
      default: begin
        // Dropping after an error: only the zero byte matters, and silently.
        if (c == CH_NUL) begin
          sc_mode  = MODE_BETWEEN;
          sc_count = 0;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // Scoreboard: predict on every accepted byte, check on every accepted result word.
  // Both sides sample at the rising edge, so the values seen are the pre-edge ones.
  always @(posedge clk) begin
    qts_result_t pred;
    qts_result_t got;
    qts_result_t want;
    if (rst_n && in_valid && !in_stall) begin
      if (sc_mode != MODE_DISCARD) live_bytes++;
      if (scan_byte(in_byte, pred)) want_q.push_back(row_typed ? row_want : pred);
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got = {out_byte, out_byte_valid, out_token_index, out_token_done, out_line_done,
             out_error_code};
      if (want_q.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("unexpected word: byte %h valid %b index %0d tdone %b ldone %b err %0d",
                   got.out_byte, got.byte_valid, got.token_index, got.token_done,
                   got.line_done, got.error_code);
      end else begin
        want = want_q.pop_front();
        if (got.out_byte    !== want.out_byte    || got.byte_valid !== want.byte_valid ||
            got.token_index !== want.token_index || got.token_done !== want.token_done ||
            got.line_done   !== want.line_done   || got.error_code !== want.error_code) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("mismatch: want %h %b %0d %b %b %0d, got %h %b %0d %b %b %0d",
                     want.out_byte, want.byte_valid, want.token_index, want.token_done,
                     want.line_done, want.error_code, got.out_byte, got.byte_valid,
                     got.token_index, got.token_done, got.line_done, got.error_code);
        end
      end
    end
  end

  // Receiver: stall at random, or hold off for a long stretch when asked, so that both
  // registers fill and the block pushes back on its input.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (press_req != press_seen) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
      press_seen <= press_req;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one byte word and hold it until the block takes it; idle first at random.
  task automatic send_byte(input logic [7:0] b, input bit typed, input qts_result_t want);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_byte   <= b;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic [7:0] bare_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (is_gap(c) || c == CH_QUOTE);
    return c;
  endfunction

  function automatic void add_gap(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) begin
      case ($urandom_range(3))
        0: line_q.push_back(CH_SPACE);
        1: line_q.push_back(CH_TAB);
        2: line_q.push_back(CH_LF);
        default: line_q.push_back(CH_CR);
      endcase
    end
  endfunction

  // Quoted body: plain characters and legal escapes, never a bare quote.
  function automatic void add_text(input int n);
    logic [7:0] c;
    repeat (n) begin
      if ($urandom_range(3) == 0) begin
        line_q.push_back(CH_BSL);
        case ($urandom_range(4))
          0: line_q.push_back(CH_N);
          1: line_q.push_back(CH_R);
          2: line_q.push_back(CH_T);
          3: line_q.push_back(CH_BSL);
          default: line_q.push_back(CH_QUOTE);
        endcase
      end else begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSL);
        line_q.push_back(c);
      end
    end
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(0, 6)) line_q.push_back(8'($urandom_range(1, 255)));
  endfunction

  // A run of well-formed tokens. Glue a quote straight onto a bare token, or a token onto
  // a closing quote, now and then: both still split into separate tokens.
  function automatic void add_tokens(input int n, input int maxlen);
    bit was_quoted;
    bit quoted;
    was_quoted = 1'b0;
    for (int i = 0; i < n; i++) begin
      quoted = ($urandom_range(99) < 40);
      if (i > 0) begin
        if (!((was_quoted && $urandom_range(99) < 20) ||
              (!was_quoted && quoted && $urandom_range(99) < 25)))
          add_gap(1, 3);
      end
      if (quoted) begin
        line_q.push_back(CH_QUOTE);
        add_text($urandom_range(0, maxlen));
        line_q.push_back(CH_QUOTE);
      end else begin
        repeat ($urandom_range(1, maxlen)) line_q.push_back(bare_char());
      end
      was_quoted = quoted;
    end
  endfunction

  // Build one line of the given shape, terminate it and send it byte by byte.
  task automatic send_line(input line_kind_t kind);
    logic [7:0] c;
    line_q.delete();
    case (kind)
      LK_PLAIN: begin
        add_gap(0, 2);
        add_tokens($urandom_range(0, 6), 5);
        add_gap(0, 2);
      end
      LK_NOISE: repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom_range(0, 255)));
      LK_OPEN: begin
        add_tokens($urandom_range(0, 3), 5);
        add_gap(1, 2);
        line_q.push_back(CH_QUOTE);
        add_text($urandom_range(0, 4));
        // Sometimes end on a pending backslash: a bad escape on the zero byte.
        if ($urandom_range(1)) line_q.push_back(CH_BSL);
      end
      LK_BAD_ESC: begin
        add_tokens($urandom_range(0, 3), 5);
        add_gap(1, 2);
        line_q.push_back(CH_QUOTE);
        add_text($urandom_range(0, 3));
        line_q.push_back(CH_BSL);
        do c = 8'($urandom_range(1, 255));
        while (c == CH_N || c == CH_R || c == CH_T || c == CH_BSL || c == CH_QUOTE);
        line_q.push_back(c);
        add_noise();
      end
      LK_FULL: begin
        add_tokens(MAX_TOKENS, 1);
        add_gap(0, 1);
      end
      LK_OVER: begin
        add_tokens(MAX_TOKENS, 1);
        add_gap(1, 1);
        line_q.push_back($urandom_range(1) ? CH_QUOTE : bare_char());
        add_noise();
      end
      default: begin
        // One token short of the limit, then a bare token closed by a quote.
        add_tokens(MAX_TOKENS - 1, 1);
        add_gap(1, 1);
        repeat ($urandom_range(1, 2)) line_q.push_back(bare_char());
        line_q.push_back(CH_QUOTE);
        add_noise();
      end
    endcase
    if (line_q.size() == 0 || line_q[$] != CH_NUL) line_q.push_back(CH_NUL);
    foreach (line_q[i]) send_byte(line_q[i], 1'b0, '0);
  endtask

  // Main sequence: reset, directed table, three random phases, drain, verdict.
  initial begin
    int         target;
    int         lines_sent;
    int         r;
    line_kind_t kind;

    // Directed table. Typed words: the empty line after reset, extreme byte values and
    // the open-quote and bad-escape error codes. Everything else is left to the model.
    dir_tab = '{
      '{8'h00, 1'b1, mk_word(8'h00, 1'b0, 6'd0, 1'b0, 1'b1, ERR_NONE)},
      '{8'hFF, 1'b1, mk_word(8'hFF, 1'b1, 6'd0, 1'b0, 1'b0, ERR_NONE)},
      '{8'h01, 1'b1, mk_word(8'h01, 1'b1, 6'd0, 1'b0, 1'b0, ERR_NONE)},
      '{CH_BSL,   1'b0, '0},  // backslash kept as is in a bare token
      '{CH_QUOTE, 1'b0, '0},  // quote ends the bare token, opens a quoted one
      '{CH_BSL,   1'b0, '0},
      '{CH_N,     1'b0, '0},
      '{CH_BSL,   1'b0, '0},
      '{CH_R,     1'b0, '0},
      '{CH_BSL,   1'b0, '0},
      '{CH_T,     1'b0, '0},
      '{CH_BSL,   1'b0, '0},
      '{CH_BSL,   1'b0, '0},
      '{CH_BSL,   1'b0, '0},
      '{CH_QUOTE, 1'b0, '0},
      '{CH_QUOTE, 1'b0, '0},  // closing quote
      '{8'h78,    1'b0, '0},  // character straight after a closing quote
      '{CH_TAB,   1'b0, '0},
      '{CH_QUOTE, 1'b0, '0},
      '{CH_BSL,   1'b0, '0},
      '{8'h41, 1'b1, mk_word(8'h00, 1'b0, 6'd3, 1'b0, 1'b0, ERR_BAD_ESCAPE)},
      '{CH_QUOTE, 1'b0, '0},  // dropped
      '{CH_NUL,   1'b0, '0},  // ends the drop without a word
      '{CH_QUOTE, 1'b0, '0},
      '{8'h00, 1'b1, mk_word(8'h00, 1'b0, 6'd0, 1'b0, 1'b1, ERR_OPEN_QUOTE)},
      '{CH_QUOTE, 1'b0, '0},
      '{CH_BSL,   1'b0, '0},
      '{8'h00, 1'b1, mk_word(8'h00, 1'b0, 6'd0, 1'b0, 1'b1, ERR_BAD_ESCAPE)},
      '{8'h62,    1'b0, '0},
      '{CH_NUL,   1'b0, '0}   // zero byte closes a bare token and the line together
    };

    // Hold reset, then release it on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_pct = 7;
    recv_pct = 80;
    foreach (dir_tab[i]) send_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);

    // Phases: sender idles lightly while the receiver stalls hard, then the reverse,
    // then full rate. Each phase opens with a long receiver hold-off.
    lines_sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_pct  = (ph == 0) ? 7 : (ph == 1) ? 80 : 0;
      recv_pct  = (ph == 0) ? 80 : (ph == 1) ? 7 : 0;
      press_req = press_req + 1;
      target    = live_bytes + PHASE_BYTES;
      while (live_bytes < target) begin
        // Walk every line shape once first, then weight towards well-formed lines.
        if (lines_sent <= int'(LK_AT_LIMIT)) begin
          kind = line_kind_t'(lines_sent);
        end else begin
          r = $urandom_range(99);
          kind = (r < 66) ? LK_PLAIN : (r < 78) ? LK_NOISE : (r < 86) ? LK_OPEN :
                 (r < 94) ? LK_BAD_ESC : (r < 96) ? LK_FULL : (r < 98) ? LK_OVER :
                 LK_AT_LIMIT;
        end
        send_line(kind);
        lines_sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed word, then a little longer for strays.
    while (want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
